// File: hw/rtl/wbja_pkg.sv
// ============================================================================
// wbja_pkg
// Shared types and constants for the windowed band-join aggregator.
// ============================================================================
package wbja_pkg;

    // Default sizing
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_BITS_DEF  = 16;

    // Fixed port field widths
    localparam int OP_W    = 2;
    localparam int FIELD_W = 16;
    localparam int CNT_OUT_W = 11;
    localparam int SPT_OUT_W = 42;
    localparam int SUM_OUT_W = 26;

    localparam logic [FIELD_W-1:0] WINDOW_RESET = 16'd5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_PROBE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [FIELD_W-1:0] price;
        logic [FIELD_W-1:0] time_req;
        logic [FIELD_W-1:0] volume;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]   probe_price;
        logic [FIELD_W-1:0]   probe_time;
        logic [FIELD_W-1:0]   probe_volume;
        logic [CNT_OUT_W-1:0] match_count;
        logic [SPT_OUT_W-1:0] sum_price_time;
        logic [SUM_OUT_W-1:0] sum_price;
        logic [SUM_OUT_W-1:0] sum_time;
        logic                 selected;
    } out_item_t;

    // Controller -> datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic probe_start;
        logic issue;
        logic mul_start;
        logic mul_step;
        logic out_load;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic pipe_busy;
        logic mul_done;
        logic out_free;
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MULT,
        ST_DONE
    } state_t;

endpackage

// File: hw/rtl/wbja_ctrl.sv
// ============================================================================
// wbja_ctrl
// Sequencer: accepts operations, walks the table scan, the serial multiply
// and the result hand-off.
// ============================================================================
module wbja_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [wbja_pkg::OP_W-1:0]  op,
    input  wbja_pkg::status_t          status,
    output wbja_pkg::cmd_t             cmd
);

    wbja_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wbja_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            wbja_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (op)
                        wbja_pkg::OP_CLEAR: cmd.clear = 1'b1;
                        wbja_pkg::OP_LOAD:  cmd.load  = 1'b1;
                        wbja_pkg::OP_PROBE: begin
                            cmd.probe_start = 1'b1;
                            state_next      = wbja_pkg::ST_SCAN;
                        end
                        default: ;  // unused code: dropped
                    endcase
                end
            end
            wbja_pkg::ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = wbja_pkg::ST_DRAIN;
                end else begin
                    cmd.issue = 1'b1;
                end
            end
            wbja_pkg::ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    cmd.mul_start = 1'b1;
                    state_next    = wbja_pkg::ST_MULT;
                end
            end
            wbja_pkg::ST_MULT: begin
                if (status.mul_done) begin
                    state_next = wbja_pkg::ST_DONE;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            wbja_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = wbja_pkg::ST_IDLE;
                end
            end
            default: state_next = wbja_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/wbja_datapath.sv
// ============================================================================
// wbja_datapath
// Row table, window match and accumulate pipeline, shift-add multipliers for
// the selection compare, and the result register.
// ============================================================================
module wbja_datapath #(
    parameter int TABLE_DEPTH = wbja_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = wbja_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [wbja_pkg::FIELD_W-1:0]  cfg_wdata,
    input  wbja_pkg::in_item_t            s_data,
    input  wbja_pkg::cmd_t                cmd,
    output wbja_pkg::status_t             status,
    output logic                          m_valid,
    input  logic                          m_ready,
    output wbja_pkg::out_item_t           m_data
);

    localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW      = $clog2(TABLE_DEPTH + 1);
    localparam int VB      = VALUE_BITS;
    localparam int SPW     = VB + CW;
    localparam int SPT_RAW = 2 * VB + CW;
    localparam int SPTW    = (SPT_RAW > 64) ? 64 : SPT_RAW;
    localparam int LPW     = CW + SPTW;
    localparam int RPW     = 2 * SPW;
    localparam int CMPW    = (LPW > RPW) ? LPW : RPW;
    localparam int WW      = (VB > wbja_pkg::FIELD_W) ? VB : wbja_pkg::FIELD_W;

    // Config and table state
    logic [wbja_pkg::FIELD_W-1:0] win_reg;
    logic [CW-1:0]                rc_reg;
    logic [2*VB-1:0]              mem [TABLE_DEPTH];

    // Probe row and scan
    wbja_pkg::in_item_t probe_reg;
    logic [VB-1:0]      pt;
    logic [CW-1:0]      addr_reg;

    // Pipeline
    logic            v1_reg;
    logic [2*VB-1:0] rd_reg;
    logic            v2_reg;
    logic [VB-1:0]   p2_price_reg, p2_time_reg;
    logic [2*VB-1:0] prod_reg;
    logic [VB-1:0]   rd_price, rd_time;
    logic            hit;

    // Accumulators
    logic [CW-1:0]   cnt_reg;
    logic [SPTW-1:0] spt_reg;
    logic [SPW-1:0]  sp_reg, st_reg;

    // Serial multipliers: cnt*spt (left), sp*st (right)
    logic [CW-1:0]   lmc_reg;
    logic [LPW-1:0]  lmd_reg, lacc_reg;
    logic [SPW-1:0]  rmc_reg;
    logic [RPW-1:0]  rmd_reg, racc_reg;

    logic m_valid_reg;
    wbja_pkg::out_item_t out_reg;

    assign pt       = VB'(probe_reg.time_req);
    assign rd_price = rd_reg[2*VB-1:VB];
    assign rd_time  = rd_reg[VB-1:0];
    assign hit      = (rd_time < pt) && (WW'(pt - rd_time) <= WW'(win_reg));

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= wbja_pkg::WINDOW_RESET;
            rc_reg      <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                win_reg <= cfg_wdata;
            end
            if (cmd.clear) begin
                rc_reg <= '0;
            end else if (cmd.load && (rc_reg < CW'(TABLE_DEPTH))) begin
                rc_reg <= rc_reg + CW'(1);
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg && hit;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Row table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.load && (rc_reg < CW'(TABLE_DEPTH))) begin
            mem[rc_reg[AW-1:0]] <= {VB'(s_data.price), VB'(s_data.time_req)};
        end
        if (cmd.issue) begin
            rd_reg <= mem[addr_reg[AW-1:0]];
        end
    end

    // Scan address, match stage, accumulate stage
    always_ff @(posedge aclk) begin
        if (cmd.probe_start) begin
            probe_reg <= s_data;
            addr_reg  <= '0;
            cnt_reg   <= '0;
            spt_reg   <= '0;
            sp_reg    <= '0;
            st_reg    <= '0;
        end else begin
            if (cmd.issue) begin
                addr_reg <= addr_reg + CW'(1);
            end
            if (v2_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                spt_reg <= spt_reg + SPTW'(prod_reg);
                sp_reg  <= sp_reg + SPW'(p2_price_reg);
                st_reg  <= st_reg + SPW'(p2_time_reg);
            end
        end
        p2_price_reg <= rd_price;
        p2_time_reg  <= rd_time;
        prod_reg     <= rd_price * rd_time;
    end

    // Shift-add multipliers, one multiplier bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            lmc_reg  <= cnt_reg;
            lmd_reg  <= LPW'(spt_reg);
            lacc_reg <= '0;
            rmc_reg  <= sp_reg;
            rmd_reg  <= RPW'(st_reg);
            racc_reg <= '0;
        end else if (cmd.mul_step) begin
            if (lmc_reg[0]) begin
                lacc_reg <= lacc_reg + lmd_reg;
            end
            if (rmc_reg[0]) begin
                racc_reg <= racc_reg + rmd_reg;
            end
            lmc_reg <= lmc_reg >> 1;
            lmd_reg <= lmd_reg << 1;
            rmc_reg <= rmc_reg >> 1;
            rmd_reg <= rmd_reg << 1;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.probe_price    <= probe_reg.price;
            out_reg.probe_time     <= probe_reg.time_req;
            out_reg.probe_volume   <= probe_reg.volume;
            out_reg.match_count    <= wbja_pkg::CNT_OUT_W'(cnt_reg);
            out_reg.sum_price_time <= wbja_pkg::SPT_OUT_W'(spt_reg);
            out_reg.sum_price      <= wbja_pkg::SUM_OUT_W'(sp_reg);
            out_reg.sum_time       <= wbja_pkg::SUM_OUT_W'(st_reg);
            out_reg.selected       <= (CMPW'(lacc_reg) > CMPW'(racc_reg));
        end
    end

    assign status.scan_done = (addr_reg == rc_reg);
    assign status.pipe_busy = v1_reg | v2_reg;
    assign status.mul_done  = (lmc_reg == '0) && (rmc_reg == '0);
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: hw/rtl/window_band_join_aggregate.sv
// ============================================================================
// window_band_join_aggregate
// Windowed band-join aggregator: row table with clear, load and probe.
// ============================================================================
// Clear and load are handled directly in the idle state. A probe scans the
// stored rows through the table's single read port at one row per cycle, then
// drains the match/accumulate pipeline, then runs two shift-add multipliers
// (count * sum_price_time and sum_price * sum_time) one bit per cycle,
// stopping early once both multiplier operands are exhausted. The next
// operation is taken while a finished result still waits in the output
// register; a following probe stalls only at its own hand-off. Loads into a
// full table are dropped, operation code 3 is ignored. The user must see that
// window_length is written through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce this. window_length resets to 5.
// ============================================================================
module window_band_join_aggregate #(
    parameter int TABLE_DEPTH = wbja_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = wbja_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // window_length register
    input  logic                          cfg_we,
    input  logic [wbja_pkg::FIELD_W-1:0]  cfg_wdata,
    // operation transfers
    input  logic                          s_valid,
    output logic                          s_ready,
    input  wbja_pkg::in_item_t            s_data,
    // probe result transfers
    output logic                          m_valid,
    input  logic                          m_ready,
    output wbja_pkg::out_item_t           m_data
);

    wbja_pkg::cmd_t    cmd;
    wbja_pkg::status_t status;

    // Sequencer: owns s_ready, steps scan/drain/multiply/hand-off
    wbja_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .op      (s_data.operation),
        .status  (status),
        .cmd     (cmd)
    );

    // Table, accumulate pipeline, multipliers and result register
    wbja_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: tb/window_sum_checker.sv
// ----------------------------------------------------------------------------
// window_sum_checker
// Watches the register port and both channels of the band-join aggregator,
// keeps its own row table, predicts every probe result and compares.
// ----------------------------------------------------------------------------
module window_sum_checker
    import wbja_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [FIELD_W-1:0] cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  in_item_t           s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  out_item_t          m_data,
    output int                 mismatches,
    output int                 awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [FIELD_W-1:0] row_price [TABLE_DEPTH_DEF];
    logic [FIELD_W-1:0] row_time  [TABLE_DEPTH_DEF];
    int                 rows_held;
    logic [FIELD_W-1:0] window;
    out_item_t          sums_due [$];

    // Aggregate over stored rows strictly older than the probe, within window.
    function automatic out_item_t window_aggregate(in_item_t probe);
        out_item_t  r;
        bit [63:0]  cnt, spt, sp, st;
        bit [127:0] lhs, rhs;
        cnt = '0;
        spt = '0;
        sp  = '0;
        st  = '0;
        for (int i = 0; i < rows_held; i++) begin
            if (row_time[i] < probe.time_req &&
                int'(probe.time_req) - int'(row_time[i]) <= int'(window)) begin
                cnt += 1;
                spt += 64'(row_price[i]) * 64'(row_time[i]);
                sp  += 64'(row_price[i]);
                st  += 64'(row_time[i]);
            end
        end
        lhs = {64'd0, cnt} * {64'd0, spt};
        rhs = {64'd0, sp} * {64'd0, st};
        r.probe_price    = probe.price;
        r.probe_time     = probe.time_req;
        r.probe_volume   = probe.volume;
        r.match_count    = cnt[CNT_OUT_W-1:0];
        r.sum_price_time = spt[SPT_OUT_W-1:0];
        r.sum_price      = sp[SUM_OUT_W-1:0];
        r.sum_time       = st[SUM_OUT_W-1:0];
        r.selected       = (lhs > rhs);
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        out_item_t want;
        if (!aresetn) begin
            rows_held  = 0;
            window     = WINDOW_RESET;
            mismatches = 0;
            sums_due.delete();
        end else begin
            if (cfg_we)
                window = cfg_wdata;
            if (s_valid && s_ready) begin
                case (s_data.operation)
                    OP_CLEAR: rows_held = 0;
                    OP_LOAD: begin
                        if (rows_held < TABLE_DEPTH_DEF) begin
                            row_price[rows_held] = s_data.price;
                            row_time[rows_held]  = s_data.time_req;
                            rows_held++;
                        end
                    end
                    OP_PROBE: sums_due = {sums_due, window_aggregate(s_data)};
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (sums_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected, got %p", $time, m_data);
                end else begin
                    want = sums_due.pop_front();
                    check_field("probe_price", want.probe_price, m_data.probe_price);
                    check_field("probe_time", want.probe_time, m_data.probe_time);
                    check_field("probe_volume", want.probe_volume, m_data.probe_volume);
                    check_field("match_count", want.match_count, m_data.match_count);
                    check_field("sum_price_time", want.sum_price_time,
                                m_data.sum_price_time);
                    check_field("sum_price", want.sum_price, m_data.sum_price);
                    check_field("sum_time", want.sum_time, m_data.sum_time);
                    check_field("selected", want.selected, m_data.selected);
                end
            end
        end
        awaited <= sums_due.size();
    end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the windowed band-join aggregator: directed
// corners, large-value rows under the widest window, then random load/probe
// groups under several window settings with random idling and back-pressure
// on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import wbja_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Longest quiet span: a full-table probe, a receiver hold-off and the settle
    // pause before a window write all fit well inside this.
    localparam int WATCHDOG_LIMIT  = 20000;
    // Settle time after the last result before touching the window register;
    // long enough to cover a full-table probe.
    localparam int SETTLE_CYCLES   = 1100;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int IDLE_PCT        = 7;

    // Unused operation code, must be ignored by the block
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [FIELD_W-1:0] cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    in_item_t           s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    out_item_t          m_data;

    int mismatches;
    int awaited;

    bit                 steady       = 1'b0;  // both sides: no random idling
    bit                 hold_off_now = 1'b0;  // ask the receiver for a long stall
    logic [FIELD_W-1:0] window_now   = WINDOW_RESET;
    int                 quiet_cycles = 0;

    window_band_join_aggregate dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    window_sum_checker sums_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random ready, plus a long hold-off on request so that the
    // output register and the probe behind it fill and s_ready drops.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_now) begin
                hold_off_now = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // One transfer on the operation channel, with an optional random gap first.
    // Valid stays up across back-to-back items; only a gap lowers it.
    task automatic send_op(logic [OP_W-1:0] op, logic [FIELD_W-1:0] price,
                           logic [FIELD_W-1:0] stamp, logic [FIELD_W-1:0] volume);
        in_item_t item;
        item.operation = op;
        item.price     = price;
        item.time_req  = stamp;
        item.volume    = volume;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic load_row(logic [FIELD_W-1:0] price, logic [FIELD_W-1:0] stamp);
        send_op(OP_LOAD, price, stamp, FIELD_W'($urandom));
    endtask

    task automatic probe_row(logic [FIELD_W-1:0] price, logic [FIELD_W-1:0] stamp,
                             logic [FIELD_W-1:0] volume);
        send_op(OP_PROBE, price, stamp, volume);
    endtask

    // Stop sending, wait until every predicted result is back, then let the
    // block finish whatever load or clear may still be in flight.
    task automatic quiesce();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_window(logic [FIELD_W-1:0] w);
        quiesce();
        cfg_wdata <= w;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        window_now  = w;
    endtask

    // Random traffic: mostly groups of loads clustered in time just below a
    // base, followed by probes at or just above that base so the window
    // actually catches rows. The rest is clears, stray loads/probes and the
    // unused opcode (the latter does not count toward n_items).
    task automatic run_traffic(int n_items);
        int                 sent;
        int                 pick;
        int                 span;
        logic [FIELD_W-1:0] base;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_op(OP_UNUSED, FIELD_W'($urandom), FIELD_W'($urandom),
                        FIELD_W'($urandom));
            end else if (pick < 12) begin
                send_op(OP_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom),
                        FIELD_W'($urandom));
                sent++;
            end else if (pick < 20) begin
                send_op(OP_LOAD + OP_W'($urandom_range(1)), FIELD_W'($urandom),
                        FIELD_W'($urandom), FIELD_W'($urandom));
                sent++;
            end else begin
                base = FIELD_W'($urandom);
                span = (window_now > 16'd30000) ? 65535 : 2 * int'(window_now) + 3;
                repeat ($urandom_range(10, 1)) begin
                    load_row(FIELD_W'($urandom), base - FIELD_W'($urandom_range(span)));
                    sent++;
                end
                repeat ($urandom_range(4, 1)) begin
                    probe_row(FIELD_W'($urandom), base + FIELD_W'($urandom_range(2)),
                              FIELD_W'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed, reset window of 5 ----
        probe_row(16'd7, 16'd100, 16'd9);                  // empty table
        send_op(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // ignored opcode
        load_row(16'd0, 16'd0);
        load_row(16'hFFFF, 16'hFFFF);
        load_row(16'd200, 16'd7);
        load_row(16'd300, 16'd5);                          // exactly window back
        load_row(16'd400, 16'd4);                          // one past window
        load_row(16'd500, 16'd10);                         // same time, excluded
        probe_row(16'hFFFF, 16'd10, 16'hFFFF);
        load_row(16'hFFFF, 16'hFFFE);
        probe_row(16'd0, 16'hFFFF, 16'd0);                 // top of time range
        probe_row(16'd1, 16'd0, 16'd1);                    // nothing below zero
        send_op(OP_CLEAR, 16'd0, 16'd0, 16'd0);
        probe_row(16'd2, 16'd10, 16'd2);                   // cleared table
        load_row(16'd1, 16'd1);
        load_row(16'd3, 16'd3);
        probe_row(16'd5, 16'd4, 16'd5);                    // flag set: 2*10 > 4*4

        // ---- zero window: nothing can match ----
        set_window(16'd0);
        load_row(16'd9, 16'd3);
        probe_row(16'd6, 16'd4, 16'd6);

        // ---- widest window, largest row values ----
        set_window(16'hFFFF);
        send_op(OP_CLEAR, 16'd0, 16'd0, 16'd0);
        load_row(16'hFFFF, 16'd0);
        probe_row(16'd3, 16'hFFFF, 16'd3);                 // full distance back
        send_op(OP_CLEAR, 16'd0, 16'd0, 16'd0);
        repeat (8) load_row(16'hFFFF, 16'hFFFE);
        probe_row(16'hFFFF, 16'hFFFF, 16'hFFFF);           // large sums
        probe_row(16'h1234, 16'hFFFE, 16'h4321);           // all rows equal time
        send_op(OP_CLEAR, 16'd0, 16'd0, 16'd0);

        // ---- random phases ----
        set_window(16'd20);
        hold_off_now = 1'b1;          // receiver stalls while items keep coming
        run_traffic(110);

        set_window(16'd1);
        steady = 1'b1;                // a stretch with no idling on either side
        run_traffic(100);
        steady = 1'b0;

        set_window(FIELD_W'($urandom_range(5000, 100)));
        run_traffic(110);

        set_window(16'hFFFF);
        send_op(OP_CLEAR, 16'd0, 16'd0, 16'd0);
        run_traffic(100);

        set_window(WINDOW_RESET);
        run_traffic(110);

        quiesce();
        if (mismatches == 0 && awaited == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
